// ===== hdl/apr_pkg.sv =====
// Package for the aging page replacement core: fixed widths and constants.
// No dependencies; imported by the core, its front end and its back end.
package apr_pkg;

	localparam int CFG_W      = 5;
	localparam int COUNT_W    = 32;
	localparam int AGE_W      = 64;
	localparam int AGE_TOP    = 63;
	localparam int CFG_RESET  = 16;

	typedef logic [CFG_W-1:0]   cfg_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [AGE_W-1:0]   age_t;

endpackage

// ===== hdl/apr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module apr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/apr_front.sv =====
// Front end of the aging page replacement core: takes page references and
// holds them in a two-entry queue for the back end. Uses apr_pkg.
module apr_front #(
	parameter int PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 q_valid,
	output logic [PAGE_BITS-1:0] q_page,
	input  logic                 q_pop
);
	import apr_pkg::*;

	logic [PAGE_BITS-1:0] slot_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push;

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != 2'd0);
	assign q_page   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= page_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hdl/apr_back.sv =====
// Back end of the aging page replacement core: lookup and minimum-age walk,
// then the aging walk, then the result register. Uses apr_pkg and apr_ram.
module apr_back #(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apr_pkg::cfg_t                 frames_cfg,
	input  logic                          q_valid,
	input  logic [PAGE_BITS-1:0]          q_page,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [$clog2(MAX_FRAMES)-1:0] frame_index,
	output apr_pkg::count_t               hit_total,
	output apr_pkg::count_t               miss_total
);
	import apr_pkg::*;

	localparam int FI_W = $clog2(MAX_FRAMES);
	localparam int CW   = $clog2(MAX_FRAMES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_AGE  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         n_q;
	logic [CW-1:0]         n_d;
	logic [MAX_FRAMES-1:0] valid_q;
	count_t                hit_cnt_q;
	count_t                miss_cnt_q;
	logic                  out_valid_q;

	logic [PAGE_BITS-1:0]  page_q;
	logic                  hit_q;
	logic [FI_W-1:0]       hidx_q;
	logic [FI_W-1:0]       midx_q;
	age_t                  least_q;

	logic [FI_W-1:0]       raddr;
	logic [FI_W-1:0]       e_idx;
	logic [FI_W-1:0]       chosen;
	logic                  last;
	age_t                  age_rd;
	age_t                  age_eff;
	age_t                  age_new;
	logic [PAGE_BITS-1:0]  tag_rd;
	logic                  age_we;
	logic                  tag_we;
	logic                  load;
	count_t                hit_cnt_d;
	count_t                miss_cnt_d;

	always_comb begin
		if (frames_cfg == '0) begin
			n_d = CW'(1);
		end else if (int'(frames_cfg) > MAX_FRAMES) begin
			n_d = CW'(MAX_FRAMES);
		end else begin
			n_d = CW'(frames_cfg);
		end
	end

	assign raddr   = cnt_q[FI_W-1:0];
	assign e_idx   = FI_W'(cnt_q - CW'(1));
	assign last    = (cnt_q == n_q);
	assign chosen  = hit_q ? hidx_q : midx_q;
	assign age_eff = valid_q[e_idx] ? age_rd : '0;
	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign age_we  = (state_q == ST_AGE) && (cnt_q != '0);
	assign tag_we  = (state_q == ST_AGE) && (cnt_q == '0) && !hit_q;
	assign load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		age_new = age_eff >> 1;
		if (e_idx == chosen) begin
			if (hit_q) begin
				age_new[AGE_TOP] = 1'b1;
			end else begin
				age_new          = '0;
				age_new[AGE_TOP] = 1'b1;
			end
		end
	end

	assign hit_cnt_d  = (hit_q && (hit_cnt_q != '1)) ? hit_cnt_q + 1'b1 : hit_cnt_q;
	assign miss_cnt_d = (!hit_q && (miss_cnt_q != '1)) ? miss_cnt_q + 1'b1 : miss_cnt_q;

	apr_ram #(
		.WIDTH(AGE_W),
		.DEPTH(MAX_FRAMES)
	) u_age_ram (
		.clk  (clk),
		.we   (age_we),
		.waddr(e_idx),
		.wdata(age_new),
		.raddr(raddr),
		.rdata(age_rd)
	);

	apr_ram #(
		.WIDTH(PAGE_BITS),
		.DEPTH(MAX_FRAMES)
	) u_tag_ram (
		.clk  (clk),
		.we   (tag_we),
		.waddr(chosen),
		.wdata(page_q),
		.raddr(raddr),
		.rdata(tag_rd)
	);

	// working registers of the walk
	always_ff @(posedge clk) begin
		if (q_pop) begin
			page_q <= q_page;
			n_q    <= n_d;
			hit_q  <= 1'b0;
		end
		if ((state_q == ST_SCAN) && (cnt_q != '0)) begin
			if (valid_q[e_idx] && (tag_rd == page_q)) begin
				hit_q  <= 1'b1;
				hidx_q <= e_idx;
			end
			if ((e_idx == '0) || (age_eff < least_q)) begin
				least_q <= age_eff;
				midx_q  <= e_idx;
			end
		end
		if (load) begin
			hit         <= hit_q;
			frame_index <= chosen;
			hit_total   <= hit_cnt_d;
			miss_total  <= miss_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			valid_q     <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_pop) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last) begin
						cnt_q   <= '0;
						state_q <= ST_AGE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_AGE: begin
					if (tag_we) begin
						valid_q[chosen] <= 1'b1;
					end
					if (last) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DONE: begin
					if (load) begin
						hit_cnt_q  <= hit_cnt_d;
						miss_cnt_q <= miss_cnt_d;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/aging_page_replacement_core.sv =====
// Aging page replacement core: one result per page reference.
// Each reference takes one walk over the tag and age memories for lookup and
// least age, then one walk to age every frame in use through the age memory's
// one read port and one write port, plus a start step and a finish step. A
// two-entry queue takes references while the walk runs, and the result
// register holds a result until it is taken. Ages and tags live in RAM; no
// clearing pass is needed.
// Uses apr_pkg, apr_front, apr_back and apr_ram.
module aging_page_replacement_core #(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [PAGE_BITS-1:0]          page_number,
	input  logic                          cfg_we,
	input  apr_pkg::cfg_t                 cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [$clog2(MAX_FRAMES)-1:0] frame_index,
	output apr_pkg::count_t               hit_total,
	output apr_pkg::count_t               miss_total
);
	import apr_pkg::*;

	cfg_t                 frames_q;
	logic                 q_valid;
	logic [PAGE_BITS-1:0] q_page;
	logic                 q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	apr_front #(
		.PAGE_BITS(PAGE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.page_number(page_number),
		.q_valid    (q_valid),
		.q_page     (q_page),
		.q_pop      (q_pop)
	);

	apr_back #(
		.MAX_FRAMES(MAX_FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.frames_cfg (frames_q),
		.q_valid    (q_valid),
		.q_page     (q_page),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.frame_index(frame_index),
		.hit_total  (hit_total),
		.miss_total (miss_total)
	);

endmodule
